/* src/wavhp_pkg.sv */
package wavhp_pkg;

  localparam int unsigned MaxChannelsDefault = 8;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [3:0] PH_RIFF     = 4'd0;
  localparam logic [3:0] PH_SIZE     = 4'd1;
  localparam logic [3:0] PH_WAVE     = 4'd2;
  localparam logic [3:0] PH_ID       = 4'd3;
  localparam logic [3:0] PH_CS_FMT   = 4'd4;
  localparam logic [3:0] PH_CS_DATA  = 4'd5;
  localparam logic [3:0] PH_CS_SKIP  = 4'd6;
  localparam logic [3:0] PH_F_FMT    = 4'd7;
  localparam logic [3:0] PH_F_CH     = 4'd8;
  localparam logic [3:0] PH_F_RATE   = 4'd9;
  localparam logic [3:0] PH_F_BRATE  = 4'd10;
  localparam logic [3:0] PH_F_ALIGN  = 4'd11;
  localparam logic [3:0] PH_F_BITS   = 4'd12;
  localparam logic [3:0] PH_DATA     = 4'd13;
  localparam logic [3:0] PH_SKIP     = 4'd14;

  localparam logic [1:0] KIND_DATA    = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] FMT_UNKNOWN = 2'd0;
  localparam logic [1:0] FMT_U8      = 2'd1;
  localparam logic [1:0] FMT_S16     = 2'd2;
  localparam logic [1:0] FMT_F32     = 2'd3;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NOT_RIFF  = 3'd1;
  localparam logic [2:0] ERR_NOT_WAVE  = 3'd2;
  localparam logic [2:0] ERR_BAD_FMT   = 3'd3;
  localparam logic [2:0] ERR_BAD_CHAN  = 3'd4;
  localparam logic [2:0] ERR_NO_DATA   = 3'd5;
  localparam logic [2:0] ERR_SHORT_FMT = 3'd6;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [15:0] AF_PCM        = 16'h0001;
  localparam logic [15:0] AF_FLOAT      = 16'h0003;
  localparam logic [15:0] AF_ALAW       = 16'h0006;
  localparam logic [15:0] AF_MULAW      = 16'h0007;
  localparam logic [15:0] AF_EXTENSIBLE = 16'hFFFE;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [1:0]  fmt_code;
    logic [15:0] channel_count;
    logic [31:0] rate_hz;
    logic [2:0]  error_code;
    logic        width_warning;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       first;
    res_t       second;
  } push_t;

  function automatic logic [31:0] padded(input logic [31:0] size);
    logic [31:0] r;
    if (size == 32'hFFFF_FFFF) begin
      r = size;
    end else begin
      r = size + {31'd0, size[0]};
    end
    return r;
  endfunction

endpackage

/* src/wavhp_parser.sv */
module wavhp_parser import wavhp_pkg::*; #(
  parameter int unsigned MaxChannels = MaxChannelsDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       acc_i,
  input  logic [7:0] byte_i,
  input  logic       eof_i,
  output push_t      push_o
);

  logic [3:0]  phase_q, phase_d;
  logic [2:0]  bi_q, bi_d;
  logic [31:0] sw_q, sw_d;
  logic [31:0] cr_q, cr_d;
  logic        fmt_seen_q, fmt_seen_d;
  logic        data_seen_q, data_seen_d;
  logic [15:0] ftag_q, ftag_d;
  logic [15:0] chan_q, chan_d;
  logic [31:0] rate_q, rate_d;
  logic [1:0]  sfmt_q, sfmt_d;
  logic        warn_q, warn_d;
  logic        failed_q, failed_d;

  logic        c_valid, e_valid;
  logic [1:0]  c_kind, e_kind;
  logic [2:0]  c_err, e_err;
  logic [2:0]  bi_inc;
  logic        field_done;
  logic [31:0] pad;
  logic [15:0] bits;
  res_t        c_res, e_res;

  always_comb begin
    phase_d     = phase_q;
    bi_d        = bi_q;
    sw_d        = sw_q;
    cr_d        = cr_q;
    fmt_seen_d  = fmt_seen_q;
    data_seen_d = data_seen_q;
    ftag_d      = ftag_q;
    chan_d      = chan_q;
    rate_d      = rate_q;
    sfmt_d      = sfmt_q;
    warn_d      = warn_q;
    failed_d    = failed_q;
    c_valid     = 1'b0;
    c_kind      = KIND_DATA;
    c_err       = ERR_NONE;
    e_valid     = 1'b0;
    e_kind      = KIND_SUMMARY;
    e_err       = ERR_NONE;
    bi_inc      = bi_q + 3'd1;
    field_done  = 1'b0;
    pad         = padded({byte_i, sw_q[31:8]});
    bits        = {byte_i, sw_q[31:24]};

    if (acc_i && !failed_q) begin
      sw_d = {byte_i, sw_q[31:8]};
      case (phase_q)
        PH_DATA: begin
          c_valid = 1'b1;
          cr_d = cr_q - 32'd1;
          if (cr_d == 32'd0) begin
            if (bi_q[0]) begin
              cr_d    = 32'd1;
              phase_d = PH_SKIP;
            end else begin
              phase_d = PH_ID;
            end
            bi_d = 3'd0;
          end
        end
        PH_SKIP: begin
          if (cr_q != 32'd0) begin
            cr_d = cr_q - 32'd1;
          end
          if (cr_d == 32'd0) begin
            phase_d = PH_ID;
            bi_d    = 3'd0;
          end
        end
        PH_F_FMT, PH_F_CH, PH_F_RATE, PH_F_BRATE, PH_F_ALIGN, PH_F_BITS: begin
          cr_d = cr_q - 32'd1;
          if (phase_q == PH_F_RATE || phase_q == PH_F_BRATE) begin
            field_done = (bi_inc == 3'd4);
          end else begin
            field_done = (bi_inc == 3'd2);
          end
          if (!field_done) begin
            bi_d = bi_inc;
          end else begin
            bi_d = 3'd0;
            if (phase_q == PH_F_FMT) begin
              ftag_d = sw_d[31:16];
            end
            if (phase_q == PH_F_FMT && ftag_d != AF_PCM && ftag_d != AF_FLOAT &&
                ftag_d != AF_ALAW && ftag_d != AF_MULAW && ftag_d != AF_EXTENSIBLE) begin
              failed_d = 1'b1;
              c_valid  = 1'b1;
              c_kind   = KIND_ERROR;
              c_err    = ERR_BAD_FMT;
            end else begin
              if (phase_q == PH_F_CH) begin
                chan_d = sw_d[31:16];
              end
              if (phase_q == PH_F_RATE) begin
                rate_d = sw_d;
              end
              if (phase_q == PH_F_BITS) begin
                if (bits == 16'd8) begin
                  sfmt_d = FMT_U8;
                end else if (bits == 16'd16) begin
                  sfmt_d = FMT_S16;
                end else if (ftag_q == AF_FLOAT && bits == 16'd32) begin
                  sfmt_d = FMT_F32;
                end else begin
                  warn_d = 1'b1;
                end
                phase_d = (cr_d == 32'd0) ? PH_ID : PH_SKIP;
              end else begin
                phase_d = phase_q + 4'd1;
              end
            end
          end
        end
        default: begin
          if (bi_inc != 3'd4) begin
            bi_d = bi_inc;
          end else begin
            bi_d = 3'd0;
            case (phase_q)
              PH_RIFF: begin
                if (sw_d != TAG_RIFF) begin
                  failed_d = 1'b1;
                  c_valid  = 1'b1;
                  c_kind   = KIND_ERROR;
                  c_err    = ERR_NOT_RIFF;
                end else begin
                  phase_d = PH_SIZE;
                end
              end
              PH_SIZE: begin
                phase_d = PH_WAVE;
              end
              PH_WAVE: begin
                if (sw_d != TAG_WAVE) begin
                  failed_d = 1'b1;
                  c_valid  = 1'b1;
                  c_kind   = KIND_ERROR;
                  c_err    = ERR_NOT_WAVE;
                end else begin
                  phase_d = PH_ID;
                end
              end
              PH_ID: begin
                if (!fmt_seen_q && sw_d == TAG_FMT) begin
                  phase_d = PH_CS_FMT;
                end else if (!data_seen_q && sw_d == TAG_DATA) begin
                  phase_d = PH_CS_DATA;
                end else begin
                  phase_d = PH_CS_SKIP;
                end
              end
              PH_CS_FMT: begin
                fmt_seen_d = 1'b1;
                if (sw_d < 32'd16) begin
                  failed_d = 1'b1;
                  c_valid  = 1'b1;
                  c_kind   = KIND_ERROR;
                  c_err    = ERR_SHORT_FMT;
                end else begin
                  cr_d    = pad;
                  phase_d = PH_F_FMT;
                end
              end
              PH_CS_DATA: begin
                data_seen_d = 1'b1;
                cr_d        = sw_d;
                if (sw_d == 32'd0) begin
                  phase_d = PH_ID;
                  bi_d    = 3'd0;
                end else begin
                  phase_d = PH_DATA;
                  bi_d    = {2'd0, sw_d[0]};
                end
              end
              default: begin
                cr_d    = pad;
                phase_d = (pad == 32'd0) ? PH_ID : PH_SKIP;
              end
            endcase
          end
        end
      endcase
    end

    c_res = '{kind: c_kind, data_byte: (c_kind == KIND_DATA) ? byte_i : 8'd0,
              fmt_code: sfmt_d, channel_count: chan_d, rate_hz: rate_d,
              error_code: c_err, width_warning: warn_d, last: (c_kind != KIND_DATA)};

    if (acc_i && eof_i) begin
      if (!failed_d) begin
        e_valid = 1'b1;
        e_kind  = KIND_ERROR;
        if (phase_d == PH_RIFF) begin
          e_err = ERR_NOT_RIFF;
        end else if (phase_d == PH_SIZE || phase_d == PH_WAVE) begin
          e_err = ERR_NOT_WAVE;
        end else if (chan_d == 16'd0 || chan_d > 16'(MaxChannels)) begin
          e_err = ERR_BAD_CHAN;
        end else if (!data_seen_d) begin
          e_err = ERR_NO_DATA;
        end else begin
          e_kind = KIND_SUMMARY;
        end
      end
      phase_d     = PH_RIFF;
      bi_d        = 3'd0;
      sw_d        = 32'd0;
      cr_d        = 32'd0;
      fmt_seen_d  = 1'b0;
      data_seen_d = 1'b0;
      ftag_d      = 16'd0;
      chan_d      = 16'd0;
      rate_d      = 32'd0;
      sfmt_d      = FMT_UNKNOWN;
      warn_d      = 1'b0;
      failed_d    = 1'b0;
    end

    e_res = '{kind: e_kind, data_byte: 8'd0, fmt_code: c_res.fmt_code,
              channel_count: c_res.channel_count, rate_hz: c_res.rate_hz,
              error_code: e_err, width_warning: c_res.width_warning, last: 1'b1};

    push_o.n      = {1'b0, c_valid} + {1'b0, e_valid};
    push_o.first  = c_valid ? c_res : e_res;
    push_o.second = e_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_RIFF;
      bi_q        <= 3'd0;
      sw_q        <= 32'd0;
      cr_q        <= 32'd0;
      fmt_seen_q  <= 1'b0;
      data_seen_q <= 1'b0;
      ftag_q      <= 16'd0;
      chan_q      <= 16'd0;
      rate_q      <= 32'd0;
      sfmt_q      <= FMT_UNKNOWN;
      warn_q      <= 1'b0;
      failed_q    <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      bi_q        <= bi_d;
      sw_q        <= sw_d;
      cr_q        <= cr_d;
      fmt_seen_q  <= fmt_seen_d;
      data_seen_q <= data_seen_d;
      ftag_q      <= ftag_d;
      chan_q      <= chan_d;
      rate_q      <= rate_d;
      sfmt_q      <= sfmt_d;
      warn_q      <= warn_d;
      failed_q    <= failed_d;
    end
  end

  a_failed_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |-> push_o.n == 2'd0)
    else $error("result produced after an error stop");

  a_two_only_at_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.n == 2'd2 |-> acc_i && eof_i)
    else $error("two results from a beat without end of file");

  a_data_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DATA |-> cr_q != 32'd0)
    else $error("data phase with no bytes left");

endmodule

/* src/wavhp_outq.sv */
module wavhp_outq import wavhp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  room_o,
  output logic  valid_o,
  input  logic  ready_i,
  output res_t  head_o
);

  res_t             ent_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d, wr_nxt;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             pop;

  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= QCntW'(QDepth - 2));
  assign head_o  = ent_q[rd_q];
  assign pop     = valid_o && ready_i;
  assign wr_nxt  = wr_q + QPtrW'(1);

  always_comb begin
    wr_d  = wr_q + QPtrW'(push_i.n);
    rd_d  = rd_q + QPtrW'(pop);
    cnt_d = cnt_q + QCntW'(push_i.n) - QCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      ent_q[wr_q] <= push_i.first;
    end
    if (push_i.n == 2'd2) begin
      ent_q[wr_nxt] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("queue count beyond depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.n != 2'd0 |-> cnt_q <= QCntW'(QDepth - 2))
    else $error("push without room");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != QCntW'(QDepth) |-> QCntW'(QPtrW'(wr_q - rd_q)) == cnt_q)
    else $error("pointers disagree with count");

endmodule

/* src/wav_header_chunk_parser_top.sv */
// byte-serial wav header walker with data chunk pass-through
// input channel: one file byte per beat (byte_value_i, end_of_file_i on the last byte),
//   handshake in_valid_i / in_ready_o
// output channel: one result per beat (kind_o, data_byte_o, fmt_code_o,
//   channel_count_o, rate_hz_o, error_code_o, width_warning_o, last_o),
//   handshake out_valid_o / out_ready_i
// each accepted byte updates the parser state in the same cycle and pushes zero,
//   one or two results into a 4-entry output queue
// each result is registered in the output queue before it appears on the output
// throughput: one byte per cycle while in_ready_o is high; the end-of-file byte may produce two results
// in_ready_o drops while three or more results wait in the queue, so a stalled
//   receiver backs up into the input once three results are pending
// reset clears the parser to expect a new riff tag and empties the queue
// after an error stop, bytes are swallowed until the end-of-file byte re-arms
//   the parser
module wav_header_chunk_parser_top import wavhp_pkg::*; #(
  parameter int unsigned MaxChannels = MaxChannelsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_value_i,
  input  logic        end_of_file_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [1:0]  fmt_code_o,
  output logic [15:0] channel_count_o,
  output logic [31:0] rate_hz_o,
  output logic [2:0]  error_code_o,
  output logic        width_warning_o,
  output logic        last_o
);

  push_t push;
  res_t  head;
  logic  room;
  logic  acc;

  assign in_ready_o = room;
  assign acc        = in_valid_i && room;

  wavhp_parser #(
    .MaxChannels(MaxChannels)
  ) u_parser (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .acc_i (acc),
    .byte_i(byte_value_i),
    .eof_i (end_of_file_i),
    .push_o(push)
  );

  wavhp_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .valid_o(out_valid_o),
    .ready_i(out_ready_i),
    .head_o (head)
  );

  assign kind_o          = head.kind;
  assign data_byte_o     = head.data_byte;
  assign fmt_code_o      = head.fmt_code;
  assign channel_count_o = head.channel_count;
  assign rate_hz_o       = head.rate_hz;
  assign error_code_o    = head.error_code;
  assign width_warning_o = head.width_warning;
  assign last_o          = head.last;

endmodule
